### sv/bile_pkg.sv
// ----------------------------------------------------------------------------
// bile_pkg
// Shared types and codes for the bounded integer list engine.
// ----------------------------------------------------------------------------
package bile_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SORT   = 3'd3,
    OP_SECOND = 3'd4,
    OP_FREQ   = 3'd5,
    OP_DUMP   = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_NONE    = 2'd3;

  localparam logic [5:0] START_LENGTH_RESET = 6'd10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SORT_OUT,
    S_SORT_IN,
    S_SEC1,
    S_SEC2,
    S_FREQ_OUT,
    S_FREQ_IN,
    S_DUMP,
    S_CLEAR
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         pos;
    logic signed [31:0] val;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         count;
    logic [1:0]         status;
    logic               last;
  } res_t;

endpackage

### sv/bile_front.sv
// ----------------------------------------------------------------------------
// bile_front
// Command intake: a two-entry queue that holds commands for the back end.
// ----------------------------------------------------------------------------
module bile_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           opcode,
  input  logic [5:0]           position,
  input  logic signed [31:0]   item_value,
  output logic                 busy,
  input  logic                 pop,
  output bile_pkg::cmd_t       head,
  output logic                 head_valid
);
  import bile_pkg::*;

  cmd_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;
  logic       do_pop;

  assign busy       = (fill == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (fill != 2'd0);
  assign head       = slot[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op_t'(opcode), pos: position, val: item_value};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

### sv/bile_back.sv
// ----------------------------------------------------------------------------
// bile_back
// Execution sequencer: walks the element store one entry per cycle.
// ----------------------------------------------------------------------------
module bile_back #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bile_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [5:0]         start_length,
  output bile_pkg::res_t     res,
  output logic               res_strobe
);
  import bile_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [31:0] store [CAPACITY];
  logic [CAPACITY-1:0] seen, seen_next;
  state_t state, state_next;
  logic [LW-1:0] len, len_next, i, i_next, j, j_next, top, top_next;
  logic [LW-1:0] cnt, cnt_next, pend_cnt, pend_cnt_next;
  logic signed [31:0] held, held_next, tv, tv_next, pend_val, pend_val_next;
  logic signed [31:0] op_val, op_val_next;
  logic [LW-1:0] op_pos, op_pos_next;
  logic pend_v, pend_v_next, first, first_next;
  logic [IW-1:0] rd_addr, wr_addr;
  logic signed [31:0] rd_data, wr_data;
  logic we;
  res_t res_next;
  logic res_strobe_next;
  logic [LW-1:0] start_clamped;

  assign rd_data = store[rd_addr];
  assign start_clamped = ({26'd0, start_length} > 32'(CAPACITY)) ? LW'(CAPACITY)
                                                                 : LW'(start_length);

  always_comb begin
    state_next      = state;
    len_next        = len;
    i_next          = i;
    j_next          = j;
    top_next        = top;
    cnt_next        = cnt;
    held_next       = held;
    tv_next         = tv;
    pend_v_next     = pend_v;
    pend_val_next   = pend_val;
    pend_cnt_next   = pend_cnt;
    first_next      = first;
    seen_next       = seen;
    op_val_next     = op_val;
    op_pos_next     = op_pos;
    rd_addr         = i[IW-1:0];
    wr_addr         = i[IW-1:0];
    wr_data         = '0;
    we              = 1'b0;
    cmd_pop         = 1'b0;
    res_strobe_next = 1'b0;
    res_next        = '{value: '0, count: 6'(len), status: STAT_OK, last: 1'b1};
    case (state)
      S_IDLE: begin
        rd_addr = IW'(cmd.pos);
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          op_val_next = cmd.val;
          op_pos_next = LW'(cmd.pos);
          case (cmd.op)
            OP_READ: begin
              res_strobe_next = 1'b1;
              if (32'(cmd.pos) >= 32'(len)) begin
                res_next.status = STAT_BAD_POS;
              end else begin
                res_next.value = rd_data;
              end
            end
            OP_INSERT: begin
              if (32'(cmd.pos) > 32'(len)) begin
                res_strobe_next = 1'b1;
                res_next.status = STAT_BAD_POS;
              end else if (32'(len) >= 32'(CAPACITY)) begin
                res_strobe_next = 1'b1;
                res_next.status = STAT_FULL;
              end else begin
                i_next     = len;
                state_next = S_SHIFT_UP;
              end
            end
            OP_REMOVE: begin
              if (32'(cmd.pos) >= 32'(len)) begin
                res_strobe_next = 1'b1;
                res_next.status = STAT_BAD_POS;
              end else begin
                i_next     = LW'(cmd.pos);
                state_next = S_SHIFT_DN;
              end
            end
            OP_SORT: begin
              i_next     = LW'(1);
              state_next = S_SORT_OUT;
            end
            OP_SECOND: begin
              if (32'(len) < 32'd2) begin
                res_strobe_next = 1'b1;
                res_next.status = STAT_NONE;
              end else begin
                i_next     = '0;
                state_next = S_SEC1;
              end
            end
            OP_FREQ: begin
              if (len == '0) begin
                res_strobe_next = 1'b1;
                res_next.status = STAT_NONE;
              end else begin
                seen_next   = '0;
                pend_v_next = 1'b0;
                i_next      = '0;
                state_next  = S_FREQ_OUT;
              end
            end
            OP_DUMP: begin
              if (len == '0) begin
                res_strobe_next = 1'b1;
                res_next.status = STAT_NONE;
              end else begin
                i_next     = '0;
                state_next = S_DUMP;
              end
            end
            OP_CLEAR: begin
              i_next     = '0;
              state_next = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        rd_addr = IW'(i - LW'(1));
        we      = 1'b1;
        if (i > op_pos) begin
          wr_data = rd_data;
          i_next  = i - LW'(1);
        end else begin
          wr_addr         = op_pos[IW-1:0];
          wr_data         = op_val;
          len_next        = len + LW'(1);
          res_strobe_next = 1'b1;
          res_next.count  = 6'(len + LW'(1));
          state_next      = S_IDLE;
        end
      end
      S_SHIFT_DN: begin
        rd_addr = IW'(i + LW'(1));
        we      = 1'b1;
        if (32'(i) + 32'd1 < 32'(len)) begin
          wr_data = rd_data;
          i_next  = i + LW'(1);
        end else begin
          wr_addr         = IW'(len - LW'(1));
          len_next        = len - LW'(1);
          res_strobe_next = 1'b1;
          res_next.count  = 6'(len - LW'(1));
          state_next      = S_IDLE;
        end
      end
      S_SORT_OUT: begin
        if (i < len) begin
          held_next  = rd_data;
          j_next     = i;
          state_next = S_SORT_IN;
        end else begin
          res_strobe_next = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SORT_IN: begin
        rd_addr = IW'(j - LW'(1));
        wr_addr = j[IW-1:0];
        we      = 1'b1;
        if (j != '0 && rd_data >= held) begin
          wr_data = rd_data;
          j_next  = j - LW'(1);
        end else begin
          wr_data    = held;
          i_next     = i + LW'(1);
          state_next = S_SORT_OUT;
        end
      end
      S_SEC1: begin
        if (i < len) begin
          if (i == '0 || rd_data > tv) begin
            tv_next  = rd_data;
            top_next = i;
          end
          i_next = i + LW'(1);
        end else begin
          i_next     = '0;
          first_next = 1'b1;
          state_next = S_SEC2;
        end
      end
      S_SEC2: begin
        if (i < len) begin
          if (i != top && (first || rd_data > held)) begin
            held_next  = rd_data;
            first_next = 1'b0;
          end
          i_next = i + LW'(1);
        end else begin
          res_strobe_next = 1'b1;
          res_next.value  = held;
          state_next      = S_IDLE;
        end
      end
      S_FREQ_OUT: begin
        if (i < len) begin
          if (seen[i[IW-1:0]]) begin
            i_next = i + LW'(1);
          end else begin
            held_next  = rd_data;
            cnt_next   = LW'(1);
            j_next     = i + LW'(1);
            state_next = S_FREQ_IN;
          end
        end else begin
          res_strobe_next = 1'b1;
          res_next.value  = pend_val;
          res_next.count  = 6'(pend_cnt);
          state_next      = S_IDLE;
        end
      end
      S_FREQ_IN: begin
        rd_addr = j[IW-1:0];
        if (j < len) begin
          if (rd_data == held) begin
            cnt_next = cnt + LW'(1);
            seen_next[j[IW-1:0]] = 1'b1;
          end
          j_next = j + LW'(1);
        end else begin
          // The previous distinct value goes out only once a later one exists,
          // so the final beat can carry the last mark.
          if (pend_v) begin
            res_strobe_next = 1'b1;
            res_next.value  = pend_val;
            res_next.count  = 6'(pend_cnt);
            res_next.last   = 1'b0;
          end
          pend_v_next   = 1'b1;
          pend_val_next = held;
          pend_cnt_next = cnt;
          i_next        = i + LW'(1);
          state_next    = S_FREQ_OUT;
        end
      end
      S_DUMP: begin
        res_strobe_next = 1'b1;
        res_next.value  = rd_data;
        res_next.last   = (i + LW'(1) == len);
        if (i + LW'(1) == len) begin
          state_next = S_IDLE;
        end else begin
          i_next = i + LW'(1);
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        if (i == LW'(CAPACITY - 1)) begin
          len_next        = start_clamped;
          res_strobe_next = 1'b1;
          res_next.count  = 6'(start_clamped);
          state_next      = S_IDLE;
        end else begin
          i_next = i + LW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    held     <= held_next;
    tv       <= tv_next;
    top      <= top_next;
    cnt      <= cnt_next;
    j        <= j_next;
    i        <= i_next;
    first    <= first_next;
    pend_val <= pend_val_next;
    pend_cnt <= pend_cnt_next;
    op_val   <= op_val_next;
    op_pos   <= op_pos_next;
    seen     <= seen_next;
    res      <= res_next;
    if (rst) begin
      state      <= S_IDLE;
      len        <= LW'(START_LENGTH_RESET > 6'(CAPACITY) && CAPACITY < 64 ?
                       LW'(CAPACITY) : LW'(START_LENGTH_RESET));
      pend_v     <= 1'b0;
      res_strobe <= 1'b0;
      for (int k = 0; k < CAPACITY; k++) begin
        store[k] <= '0;
      end
    end else begin
      state      <= state_next;
      len        <= len_next;
      pend_v     <= pend_v_next;
      res_strobe <= res_strobe_next;
      if (we) begin
        store[wr_addr] <= wr_data;
      end
    end
  end

endmodule

### sv/bounded_integer_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_integer_list_engine
// Ordered list of signed 32-bit values with edit, sort and report commands.
// ----------------------------------------------------------------------------
// Read answers without walking the store; insert and remove shift the entries,
// dump gives one result beat per element, and clear walks every store entry.
// Sort and frequency use nested walks of the list; one store entry is read per cycle.
// Commands wait in a two-entry queue; busy is high only when both are in use.
// Synchronous reset empties the queue, zeros the store and sets length to 10.
module bounded_integer_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [5:0]         position,
  input  logic signed [31:0] item_value,
  output logic               result_strobe,
  output logic signed [31:0] result_value,
  output logic [5:0]         result_count,
  output logic [1:0]         status,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bile_pkg::*;

  cmd_t       head;
  logic       head_valid;
  logic       pop;
  res_t       res;
  logic [5:0] start_length;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, start_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_length <= START_LENGTH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      start_length <= pwdata[5:0];
    end
  end

  bile_front u_front (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .position(position),
    .item_value(item_value), .busy(busy), .pop(pop), .head(head),
    .head_valid(head_valid)
  );

  bile_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .cmd(head), .cmd_valid(head_valid), .cmd_pop(pop),
    .start_length(start_length), .res(res), .res_strobe(result_strobe)
  );

  assign result_value = res.value;
  assign result_count = res.count;
  assign status       = res.status;
  assign last         = res.last;

endmodule

### sv/bile_checker.sv
// ----------------------------------------------------------------------------
// bile_checker
// Port-level checks on result beats of the list engine.
// ----------------------------------------------------------------------------
module bile_checker #(
  parameter int CAPACITY = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               result_strobe,
  input logic signed [31:0] result_value,
  input logic [5:0]         result_count,
  input logic [1:0]         status,
  input logic               last
);
  import bile_pkg::*;

  // Any error beat ends its command.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status != STAT_OK |-> last)
    else $error("error beat without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status != STAT_OK |-> result_value == 32'sd0)
    else $error("error beat carries a value");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == STAT_FULL |-> result_count == 6'(CAPACITY))
    else $error("full status with short list");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_strobe)
    else $error("activity right after reset");

endmodule

bind bounded_integer_list_engine bile_checker #(.CAPACITY(CAPACITY)) u_bile_checker (
  .clk(clk), .rst(rst), .busy(busy), .result_strobe(result_strobe),
  .result_value(result_value), .result_count(result_count), .status(status),
  .last(last)
);
